// File: sv/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_ADD_FRONT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_BACK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_QUERY_EMPTY  = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [WORD_W-1:0] data_in;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data_out;
		logic                     is_empty;
		logic [STAT_W-1:0]        status;
	} rsp_beat_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} deq_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_valid;
	} deq_stat_t;

endpackage

// File: sv/deq_ctrl.sv
// Sequencing state machine for the double-ended queue.
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic               rsp_stall,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_ctl_t  ctl
);
	import deq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   slot_free;

	assign slot_free  = !stat.rsp_valid || !rsp_stall;
	assign cmd_stall  = (state_q != S_IDLE);
	assign ctl.load   = (state_q == S_IDLE) && cmd_valid;
	assign ctl.exec   = (state_q == S_EXEC);
	assign ctl.finish = (state_q == S_DONE) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd_valid) state_d = S_EXEC;
			S_EXEC: state_d = S_DONE;
			S_DONE: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/deq_dpath.sv
// Ring store, indices, entry count and result register of the double-ended queue.
module deq_dpath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::cmd_beat_t cmd,
	input  logic               rsp_stall,
	input  deq_pkg::deq_ctl_t  ctl,
	output deq_pkg::deq_stat_t stat,
	output logic               rsp_valid,
	output deq_pkg::rsp_beat_t rsp
);
	import deq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [CMD_W-1:0]  cmd_q;
	logic [WORD_W-1:0] word_q;
	logic [AW-1:0]     front_q, back_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] rd_q;
	logic              use_rd_q;
	logic [STAT_W-1:0] status_q;
	logic              empty_q;
	logic              rsp_valid_q;
	rsp_beat_t         rsp_q;

	logic          is_add, is_take, full, empty;
	logic [AW-1:0] front_dec, front_inc, back_dec, back_inc;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en;
	logic [CW-1:0] count_d;
	logic [AW-1:0] front_d, back_d;
	logic [STAT_W-1:0] status_d;

	assign is_add  = (cmd_q == CMD_ADD_FRONT) || (cmd_q == CMD_ADD_BACK);
	assign is_take = (cmd_q == CMD_REMOVE_FRONT) || (cmd_q == CMD_REMOVE_BACK) ||
			(cmd_q == CMD_PEEK_FRONT) || (cmd_q == CMD_PEEK_BACK);
	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	// wrap in both directions, depth need not be a power of two
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign back_dec  = (back_q == '0) ? LAST_IDX : back_q - AW'(1);
	assign back_inc  = (back_q == LAST_IDX) ? '0 : back_q + AW'(1);

	assign wr_addr = (cmd_q == CMD_ADD_FRONT) ? front_dec : back_q;
	assign rd_addr = ((cmd_q == CMD_REMOVE_BACK) || (cmd_q == CMD_PEEK_BACK)) ?
			back_dec : front_q;
	assign wr_en   = ctl.exec && is_add && !full;

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		status_d = ST_OK;
		if (is_add && full) begin
			status_d = ST_FULL;
		end else if (is_take && empty) begin
			status_d = ST_EMPTY;
		end else begin
			unique case (cmd_q)
				CMD_ADD_FRONT: begin
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
				CMD_ADD_BACK: begin
					back_d  = back_inc;
					count_d = count_q + CW'(1);
				end
				CMD_REMOVE_FRONT: begin
					front_d = front_inc;
					count_d = count_q - CW'(1);
				end
				CMD_REMOVE_BACK: begin
					back_d  = back_dec;
					count_d = count_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// read only in the execute cycle so the word holds while the result waits
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (ctl.exec) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd.command;
			word_q <= cmd.data_in;
		end
		if (ctl.exec) begin
			use_rd_q <= is_take && !empty;
			status_q <= status_d;
			empty_q  <= (count_d == '0);
		end
		if (ctl.finish) begin
			rsp_q.data_out <= use_rd_q ? rd_q : '0;
			rsp_q.is_empty <= empty_q;
			rsp_q.status   <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				front_q <= front_d;
				back_q  <= back_d;
				count_q <= count_d;
			end
			// hold the beat while stalled, drop it once taken
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.rsp_valid = rsp_valid_q;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

endmodule

// File: sv/double_ended_queue_top.sv
// Top level of the double-ended queue: controller plus datapath.
//
//   channel | direction | payload    | handshake
//   cmd     | in        | cmd_beat_t | cmd_valid / cmd_stall
//   rsp     | out       | rsp_beat_t | rsp_valid / rsp_stall
//
// Each command passes through capture, execute (index update plus one
// access to the ring memory, whose read data is registered), and result load.
// The result load waits while a previous result beat is still stalled.
// Reset clears indices, count and the result valid; the memory holds no reset.
// cmd_stall is high from the cycle after a beat is taken until its result loads.
module double_ended_queue_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  deq_pkg::cmd_beat_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output deq_pkg::rsp_beat_t rsp
);
	import deq_pkg::*;

	deq_ctl_t  ctl;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: sv/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input deq_pkg::rsp_beat_t rsp
);
	import deq_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while another is in flight");

	// a result appears only after a command has been worked on
	a_rsp_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("result beat without a command in flight");

	// an empty error always reports an empty queue and no data
	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.is_empty && (rsp.data_out == '0))
		else $error("empty error with data or non-empty flag");

	// a full error returns no data and a non-empty queue
	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> !rsp.is_empty && (rsp.data_out == '0))
		else $error("full error with data or empty flag");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
